FILE: rtl/tdft_pkg.sv
package tdft_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int SLOT_W      = $clog2(TABLE_DEPTH + 1);

   localparam int NUM_W = 31;
   localparam int IDX_W = 10;
   localparam int DIV_W = 16;
   localparam int CNT_W = 32;
   localparam int SQ_W  = 32;

   localparam int FIRST_DIVISOR = 2;

   // The remainder unit retires one dividend bit per cycle.
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam int REQ_TDATA_W  = 48;
   localparam int RSP_FIELDS_W = 146;
   localparam int RSP_TDATA_W  = 152;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;
   localparam int REQ_PAD_W    = REQ_TDATA_W - NUM_W - IDX_W;

   typedef enum logic [0:0] {
      ACT_TEST = 1'b0,
      ACT_READ = 1'b1
   } action_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } mod_status_type;

   typedef struct packed {
      logic [DIV_W-1:0] divisor;
      logic [CNT_W-1:0] count;
   } slot_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

endpackage

FILE: rtl/tdft_mod_unit.sv
module tdft_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tdft_pkg::NUM_W-1:0]  dividend,
   input  logic [tdft_pkg::DIV_W-1:0]  divisor,
   output tdft_pkg::mod_status_type    status
);

   logic                        busy_ff,     busy_in;
   logic                        done_ff,     done_in;
   logic [tdft_pkg::STEP_W-1:0] step_ff,     step_in;
   logic [tdft_pkg::NUM_W-1:0]  shift_ff,    shift_in;
   logic [tdft_pkg::DIV_W-1:0]  div_ff,      div_in;
   logic [tdft_pkg::DIV_W-1:0]  rem_ff,      rem_in;
   logic [tdft_pkg::DIV_W:0]    trial;

   // Restoring remainder: shift in the next dividend bit, subtract if it fits.
   assign trial = {rem_ff, shift_ff[tdft_pkg::NUM_W-1]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = tdft_pkg::STEP_W'(tdft_pkg::DIV_STEPS - 1);
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[tdft_pkg::NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = tdft_pkg::DIV_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[tdft_pkg::DIV_W-1:0];
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - tdft_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit started while busy");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("remainder unit done while still busy");

   a_done_after_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && step_ff == '0) |=> done_ff)
      else $error("remainder unit missed its done pulse");

endmodule

FILE: rtl/trial_division_factor_tally_top.sv
// Each request beat either tests a number by trial division (req_tuser low) or reads one
// slot of the smallest-divisor tally table (req_tuser high), and gives exactly one response
// beat. A test tries divisors 2, 3, 4, ... while d*d <= number on a single bit-serial
// remainder unit; each trial is one square compare, 31 remainder steps and one result
// check. A composite then scans the used table slots, a read state and a compare state
// per slot, over the single table read port before it counts or appends its divisor, or
// flags a full table in status. Numbers below two go straight to the finish state; a
// readout passes through one read-wait state. The table is not cleared after reset; only
// slots below the fill count are read. One item is in work at a time, but a new request
// is taken while the previous response beat is still waiting.
module trial_division_factor_tally_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // number [30:0], entry_index [40:31], zero fill [47:41]
   input  logic [tdft_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // is_prime [0], smallest_divisor [16:1], divisor_tally [48:17], status [49],
   // prime_total [81:50], largest_divisor [97:82], entry_divisor [113:98],
   // entry_count [145:114], zero fill [151:146]
   output logic [tdft_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_CHECK     = 7'b0000010,
      ST_DIVIDE    = 7'b0000100,
      ST_SCAN_RD   = 7'b0001000,
      ST_SCAN_CMP  = 7'b0010000,
      ST_READ_WAIT = 7'b0100000,
      ST_FINISH    = 7'b1000000
   } state_type;

   state_type                       state_ff,      state_in;
   logic [tdft_pkg::NUM_W-1:0]      num_ff,        num_in;
   logic [tdft_pkg::IDX_W-1:0]      idx_ff,        idx_in;
   logic [tdft_pkg::DIV_W-1:0]      d_ff,          d_in;
   logic [tdft_pkg::SQ_W-1:0]       sq_ff,         sq_in;
   logic [tdft_pkg::SLOT_W-1:0]     scan_ff,       scan_in;
   logic [tdft_pkg::CNT_W-1:0]      prime_cnt_ff,  prime_cnt_in;
   logic [tdft_pkg::DIV_W-1:0]      max_div_ff,    max_div_in;
   logic [tdft_pkg::SLOT_W-1:0]     slots_ff,      slots_in;
   logic                            res_prime_ff,  res_prime_in;
   logic [tdft_pkg::DIV_W-1:0]      res_sdiv_ff,   res_sdiv_in;
   logic [tdft_pkg::CNT_W-1:0]      res_tally_ff,  res_tally_in;
   logic                            res_status_ff, res_status_in;
   logic [tdft_pkg::DIV_W-1:0]      res_ediv_ff,   res_ediv_in;
   logic [tdft_pkg::CNT_W-1:0]      res_ecnt_ff,   res_ecnt_in;
   logic                            rsp_valid_ff,  rsp_valid_in;
   logic [tdft_pkg::RSP_TDATA_W-1:0] rsp_data_ff,  rsp_data_in;

   tdft_pkg::slot_type              tbl_mem [tdft_pkg::TABLE_DEPTH];
   tdft_pkg::slot_type              rd_data_ff;
   logic [tdft_pkg::ADDR_W-1:0]     rd_addr;
   logic                            mem_we;
   logic [tdft_pkg::ADDR_W-1:0]     mem_waddr;
   tdft_pkg::slot_type              mem_wdata;

   logic                            mod_start;
   tdft_pkg::mod_status_type        mod_stat;

   logic                            req_fire;
   tdft_pkg::action_type            req_action;
   logic [tdft_pkg::NUM_W-1:0]      req_number;
   logic [tdft_pkg::IDX_W-1:0]      req_index;
   logic [tdft_pkg::DIV_W-1:0]      new_max;

   assign req_action = tdft_pkg::action_type'(req_tuser);
   assign req_number = req_tdata[tdft_pkg::NUM_W-1:0];
   assign req_index  = req_tdata[tdft_pkg::NUM_W +: tdft_pkg::IDX_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign new_max = (d_ff > max_div_ff) ? d_ff : max_div_ff;

   // The table read port follows the request index while idle, the scan pointer otherwise.
   assign rd_addr = (state_ff == ST_IDLE) ? tdft_pkg::ADDR_W'(req_index)
                                          : scan_ff[tdft_pkg::ADDR_W-1:0];

   tdft_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (num_ff),
      .divisor  (d_ff),
      .status   (mod_stat)
   );

   always_comb begin
      state_in      = state_ff;
      num_in        = num_ff;
      idx_in        = idx_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      scan_in       = scan_ff;
      prime_cnt_in  = prime_cnt_ff;
      max_div_in    = max_div_ff;
      slots_in      = slots_ff;
      res_prime_in  = res_prime_ff;
      res_sdiv_in   = res_sdiv_ff;
      res_tally_in  = res_tally_ff;
      res_status_in = res_status_ff;
      res_ediv_in   = res_ediv_ff;
      res_ecnt_in   = res_ecnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mod_start     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = scan_ff[tdft_pkg::ADDR_W-1:0];
      mem_wdata     = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               num_in        = req_number;
               idx_in        = req_index;
               d_in          = tdft_pkg::DIV_W'(tdft_pkg::FIRST_DIVISOR);
               sq_in         = tdft_pkg::SQ_W'(tdft_pkg::FIRST_DIVISOR *
                                               tdft_pkg::FIRST_DIVISOR);
               res_prime_in  = 1'b0;
               res_sdiv_in   = '0;
               res_tally_in  = '0;
               res_status_in = 1'b0;
               res_ediv_in   = '0;
               res_ecnt_in   = '0;
               if (req_action == tdft_pkg::ACT_READ) begin
                  state_in = ST_READ_WAIT;
               end else if (req_number < tdft_pkg::NUM_W'(tdft_pkg::FIRST_DIVISOR)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sq_ff > tdft_pkg::SQ_W'(num_ff)) begin
               res_prime_in = 1'b1;
               prime_cnt_in = tdft_pkg::sat_inc(prime_cnt_ff);
               state_in     = ST_FINISH;
            end else begin
               mod_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (mod_stat.done) begin
               if (mod_stat.rem_zero) begin
                  res_sdiv_in = d_ff;
                  scan_in     = '0;
                  state_in    = ST_SCAN_RD;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  sq_in    = sq_ff + tdft_pkg::SQ_W'({d_ff, 1'b0}) + tdft_pkg::SQ_W'(1);
                  d_in     = d_ff + tdft_pkg::DIV_W'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_SCAN_RD: begin
            if (scan_ff < slots_ff) begin
               state_in = ST_SCAN_CMP;
            end else begin
               // Divisor not in the table: append it if a slot is free.
               max_div_in = new_max;
               state_in   = ST_FINISH;
               if (slots_ff < tdft_pkg::SLOT_W'(tdft_pkg::TABLE_DEPTH)) begin
                  mem_we            = 1'b1;
                  mem_waddr         = slots_ff[tdft_pkg::ADDR_W-1:0];
                  mem_wdata.divisor = d_ff;
                  mem_wdata.count   = tdft_pkg::CNT_W'(1);
                  slots_in          = slots_ff + tdft_pkg::SLOT_W'(1);
                  res_tally_in      = tdft_pkg::CNT_W'(1);
               end else begin
                  res_status_in = 1'b1;
               end
            end
         end
         ST_SCAN_CMP: begin
            if (rd_data_ff.divisor == d_ff) begin
               mem_we            = 1'b1;
               mem_wdata.divisor = d_ff;
               mem_wdata.count   = tdft_pkg::sat_inc(rd_data_ff.count);
               res_tally_in      = tdft_pkg::sat_inc(rd_data_ff.count);
               max_div_in        = new_max;
               state_in          = ST_FINISH;
            end else begin
               scan_in  = scan_ff + tdft_pkg::SLOT_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_READ_WAIT: begin
            if (32'(idx_ff) < 32'(slots_ff)) begin
               res_ediv_in = rd_data_ff.divisor;
               res_ecnt_in = rd_data_ff.count;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{tdft_pkg::RSP_PAD_W{1'b0}}, res_ecnt_ff, res_ediv_ff,
                               max_div_ff, prime_cnt_ff, res_status_ff, res_tally_ff,
                               res_sdiv_ff, res_prime_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prime_cnt_ff <= '0;
         max_div_ff   <= '0;
         slots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prime_cnt_ff <= prime_cnt_in;
         max_div_ff   <= max_div_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff        <= num_in;
      idx_ff        <= idx_in;
      d_ff          <= d_in;
      sq_ff         <= sq_in;
      scan_ff       <= scan_in;
      res_prime_ff  <= res_prime_in;
      res_sdiv_ff   <= res_sdiv_in;
      res_tally_ff  <= res_tally_in;
      res_status_ff <= res_status_in;
      res_ediv_ff   <= res_ediv_in;
      res_ecnt_ff   <= res_ecnt_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= tbl_mem[rd_addr];
   end

   a_slots_bounded: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= tdft_pkg::SLOT_W'(tdft_pkg::TABLE_DEPTH))
      else $error("table fill count beyond depth");

   a_mod_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      mod_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("remainder result arrived outside the divide state");

   a_prime_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && prime_cnt_ff != $past(prime_cnt_ff))
         |-> (prime_cnt_ff == $past(prime_cnt_ff) + tdft_pkg::CNT_W'(1)))
      else $error("prime count moved by more than one");

   a_max_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (max_div_ff >= $past(max_div_ff)))
      else $error("largest divisor decreased");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start work");

endmodule

FILE: tb/trial_division_factor_tally_checker.sv
`timescale 1ns / 1ps

module trial_division_factor_tally_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // number [30:0], entry_index [40:31], zero fill [47:41]
   input  logic [tdft_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action [0]
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // is_prime [0], smallest_divisor [16:1], divisor_tally [48:17], status [49],
   // prime_total [81:50], largest_divisor [97:82], entry_divisor [113:98],
   // entry_count [145:114], zero fill [151:146]
   input  logic [tdft_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output int                                fail_count,
   output int                                pending
);

   typedef struct packed {
      logic                       is_prime;
      logic [tdft_pkg::DIV_W-1:0] smallest_divisor;
      logic [tdft_pkg::CNT_W-1:0] divisor_tally;
      logic                       status;
      logic [tdft_pkg::CNT_W-1:0] prime_total;
      logic [tdft_pkg::DIV_W-1:0] largest_divisor;
      logic [tdft_pkg::DIV_W-1:0] entry_divisor;
      logic [tdft_pkg::CNT_W-1:0] entry_count;
   } factor_reply_type;

   // Shadow of the block's counters and tally table.
   logic [tdft_pkg::CNT_W-1:0] primes_found;
   logic [tdft_pkg::DIV_W-1:0] widest_divisor;
   int                         slots_filled;
   logic [tdft_pkg::DIV_W-1:0] seen_divisor [tdft_pkg::TABLE_DEPTH];
   logic [tdft_pkg::CNT_W-1:0] seen_count [tdft_pkg::TABLE_DEPTH];
   factor_reply_type           replies_due [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic [tdft_pkg::CNT_W-1:0] saturating_bump(
         input logic [tdft_pkg::CNT_W-1:0] v);
      return (v == {tdft_pkg::CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   // Smallest d with d*d <= n that divides n, or zero when there is none.
   function automatic logic [tdft_pkg::DIV_W-1:0] least_factor(
         input logic [tdft_pkg::NUM_W-1:0] n);
      longint unsigned d;
      longint unsigned wide_n;
      wide_n = n;
      for (d = tdft_pkg::FIRST_DIVISOR; d * d <= wide_n; d++) begin
         if (wide_n % d == 0) return tdft_pkg::DIV_W'(d);
      end
      return '0;
   endfunction

   function automatic factor_reply_type factor_and_tally(
         input tdft_pkg::action_type         act,
         input logic [tdft_pkg::NUM_W-1:0]   num,
         input logic [tdft_pkg::IDX_W-1:0]   idx);
      factor_reply_type           r;
      logic [tdft_pkg::DIV_W-1:0] d;
      bit                         hit;
      r = '0;
      if (act == tdft_pkg::ACT_READ) begin
         if (int'(idx) < slots_filled) begin
            r.entry_divisor = seen_divisor[idx];
            r.entry_count   = seen_count[idx];
         end
      end else if (num >= tdft_pkg::FIRST_DIVISOR) begin
         d = least_factor(num);
         if (d == 0) begin
            r.is_prime   = 1'b1;
            primes_found = saturating_bump(primes_found);
         end else begin
            r.smallest_divisor = d;
            hit = 1'b0;
            for (int i = 0; i < slots_filled; i++) begin
               if (!hit && seen_divisor[i] == d) begin
                  seen_count[i]   = saturating_bump(seen_count[i]);
                  r.divisor_tally = seen_count[i];
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               if (slots_filled < tdft_pkg::TABLE_DEPTH) begin
                  seen_divisor[slots_filled] = d;
                  seen_count[slots_filled]   = 1;
                  slots_filled++;
                  r.divisor_tally = 1;
               end else begin
                  r.status = 1'b1;
               end
            end
            if (d > widest_divisor) widest_divisor = d;
         end
      end
      r.prime_total     = primes_found;
      r.largest_divisor = widest_divisor;
      return r;
   endfunction

   task automatic check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      factor_reply_type want;
      if (reset) begin
         primes_found   = '0;
         widest_divisor = '0;
         slots_filled   = 0;
         replies_due.delete();
      end else begin
         // Retire the outgoing beat first so a beat can never match its own request.
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               fail_count++;
               $display("%0t ns: response beat with nothing expected, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = replies_due.pop_front();
               check_field("is_prime", want.is_prime, rsp_tdata[0]);
               check_field("smallest_divisor", want.smallest_divisor, rsp_tdata[16:1]);
               check_field("divisor_tally", want.divisor_tally, rsp_tdata[48:17]);
               check_field("status", want.status, rsp_tdata[49]);
               check_field("prime_total", want.prime_total, rsp_tdata[81:50]);
               check_field("largest_divisor", want.largest_divisor, rsp_tdata[97:82]);
               check_field("entry_divisor", want.entry_divisor, rsp_tdata[113:98]);
               check_field("entry_count", want.entry_count, rsp_tdata[145:114]);
               check_field("zero fill", 0,
                           rsp_tdata[tdft_pkg::RSP_TDATA_W-1:tdft_pkg::RSP_FIELDS_W]);
            end
         end
         if (req_tvalid && req_tready) begin
            replies_due.push_back(factor_and_tally(
               tdft_pkg::action_type'(req_tuser),
               req_tdata[tdft_pkg::NUM_W-1:0],
               req_tdata[tdft_pkg::NUM_W+tdft_pkg::IDX_W-1:tdft_pkg::NUM_W]));
         end
      end
      pending <= replies_due.size();
   end

endmodule

FILE: tb/tb_trial_division_factor_tally_top.sv
`timescale 1ns / 1ps

module tb_trial_division_factor_tally_top;

   localparam int RANDOM_ITEMS = 750;
   localparam int CALM_TAIL    = 80;
   localparam int DRAIN_CYCLES = 40;

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [tdft_pkg::REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                              req_tuser  = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [tdft_pkg::RSP_TDATA_W-1:0]  rsp_tdata;
   int                                fail_count;
   int                                pending;

   bit                                calm = 1'b0;
   bit                                running = 1'b0;
   int                                tests_sent = 0;
   int                                reads_sent = 0;

   trial_division_factor_tally_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   trial_division_factor_tally_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Holds one beat until it is taken, then sometimes leaves a gap.
   task automatic send_item(input tdft_pkg::action_type       act,
                            input logic [tdft_pkg::NUM_W-1:0] num,
                            input logic [tdft_pkg::IDX_W-1:0] idx);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{tdft_pkg::REQ_PAD_W{1'b0}}, idx, num};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == tdft_pkg::ACT_READ) reads_sent++;
      else tests_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Most candidates are cheap to factor; large primes would dominate the run time.
   function automatic logic [tdft_pkg::NUM_W-1:0] pick_number();
      int unsigned sel;
      int unsigned q;
      sel = $urandom_range(0, 99);
      if (sel < 5) return tdft_pkg::NUM_W'($urandom_range(0, 3));
      if (sel < 55) return tdft_pkg::NUM_W'($urandom_range(2, 4095));
      if (sel < 70) return tdft_pkg::NUM_W'($urandom) & ~tdft_pkg::NUM_W'(1);
      if (sel < 85) return tdft_pkg::NUM_W'(3 * $urandom_range(0, 715827882));
      if (sel < 95) begin
         q = $urandom_range(2, 300);
         return tdft_pkg::NUM_W'(q * q);
      end
      return tdft_pkg::NUM_W'($urandom_range(2, 1 << 20));
   endfunction

   always @(posedge clock) begin
      if (running && rsp_tready && !calm && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      logic [tdft_pkg::IDX_W-1:0] idx;
      repeat (12) @(posedge clock);
      reset      <= 1'b0;
      rsp_tready <= 1'b1;
      running    = 1'b1;

      send_item(tdft_pkg::ACT_TEST, 0, 0);
      send_item(tdft_pkg::ACT_TEST, 1, 0);
      send_item(tdft_pkg::ACT_READ, 0, 0);             // empty table reads back zero
      send_item(tdft_pkg::ACT_TEST, 2, 0);
      send_item(tdft_pkg::ACT_TEST, 3, 0);
      send_item(tdft_pkg::ACT_TEST, 4, 0);             // first divisor appended
      send_item(tdft_pkg::ACT_TEST, 6, 0);             // known divisor counted up
      send_item(tdft_pkg::ACT_TEST, 9, 0);             // square of a prime is composite
      send_item(tdft_pkg::ACT_TEST, 25, 0);
      send_item(tdft_pkg::ACT_TEST, 31'h7FFF_FFFE, 0);
      send_item(tdft_pkg::ACT_TEST, 31'h7FFF_FFFD, 0);
      send_item(tdft_pkg::ACT_TEST, 65521, 0);
      send_item(tdft_pkg::ACT_TEST, 64507, 0);         // 251 * 257
      send_item(tdft_pkg::ACT_TEST, 49, 0);            // smaller divisor leaves the maximum alone
      send_item(tdft_pkg::ACT_TEST, 15, {tdft_pkg::IDX_W{1'b1}});
      for (int i = 0; i < 6; i++) send_item(tdft_pkg::ACT_READ, 0, tdft_pkg::IDX_W'(i));
      // The number field is ignored on readout.
      send_item(tdft_pkg::ACT_READ, {tdft_pkg::NUM_W{1'b1}}, 0);
      send_item(tdft_pkg::ACT_READ, 0, {tdft_pkg::IDX_W{1'b1}});

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= RANDOM_ITEMS - CALM_TAIL);
         idx  = ($urandom_range(0, 1) == 0) ? tdft_pkg::IDX_W'($urandom_range(0, 40))
                                            : tdft_pkg::IDX_W'($urandom);
         if ($urandom_range(0, 3) == 0) begin
            send_item(tdft_pkg::ACT_READ, tdft_pkg::NUM_W'($urandom), idx);
         end else begin
            send_item(tdft_pkg::ACT_TEST, pick_number(), idx);
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d number tests and %0d table readouts,", tests_sent, reads_sent);
      $display("with random idling on both channels and a calm stretch at the end.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: trial_division_factor_tally_top.f
rtl/tdft_pkg.sv
rtl/tdft_mod_unit.sv
rtl/trial_division_factor_tally_top.sv
tb/trial_division_factor_tally_checker.sv
tb/tb_trial_division_factor_tally_top.sv
